// File: hdl/psch_pkg.sv
// ----------------------------------------------------------------------------
// psch_pkg
// Shared constants, codes and types of the preemptive priority scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package psch_pkg;

	localparam int MAX_PROCS = 16;
	localparam int IDX_W     = $clog2(MAX_PROCS);
	localparam int CNT_W     = $clog2(MAX_PROCS + 1);

	localparam int FUNC_W = 2;
	localparam int TIME_W = 16;
	localparam int PRIO_W = 8;
	localparam int PID_W  = 5;
	localparam int TICK_W = 32;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_LOAD  = 2'd1,
		FUNC_TICK  = 2'd2
	} psch_func_t;

	typedef struct packed {
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] burst;
		logic [TIME_W-1:0] remaining;
		logic [PRIO_W-1:0] prio;
	} psch_entry_t;

	localparam int ENTRY_W = $bits(psch_entry_t);

	typedef struct packed {
		logic found;
		logic [PRIO_W-1:0] best_prio;
	} psch_best_t;

endpackage

`default_nettype wire

// File: hdl/psch_ram.sv
// ----------------------------------------------------------------------------
// psch_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module psch_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: hdl/psch_cmp.sv
// ----------------------------------------------------------------------------
// psch_cmp
// Shared compare unit: tests one table word for readiness and against the
// best candidate found so far in the current scan.
// ----------------------------------------------------------------------------
`default_nettype none

module psch_cmp (
	input  wire psch_pkg::psch_entry_t        word,
	input  wire logic [psch_pkg::TICK_W-1:0]  tick,
	input  wire psch_pkg::psch_best_t         best,
	output logic                              take
);

	import psch_pkg::*;

	logic ready_word;

	always_comb begin
		ready_word = (word.remaining != '0) && (TICK_W'(word.arrival) <= tick);
		take       = ready_word && (!best.found || (word.prio < best.best_prio));
	end

endmodule

`default_nettype wire

// File: hdl/preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Preemptive priority scheduler over a table of up to MAX_PROCS processes.
// ----------------------------------------------------------------------------
// A clear or load word gives no result. A tick word yields one result word:
// the table sits in one RAM and, unless it is empty, a single priority
// comparator walks it one entry per cycle through the RAM read port, after
// which the chosen entry is written back and completion, turnaround and
// waiting are formed in turn in the CT, TAT and WT states. The block takes no
// new word while a tick is in progress; a result word waiting at the output
// does not hold off the next clear or load.
`default_nettype none

module preemptive_priority_scheduler (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cmd_valid,
	output logic                               cmd_ready,
	input  wire logic [psch_pkg::FUNC_W-1:0]   func,
	input  wire logic [psch_pkg::TIME_W-1:0]   arrival_time,
	input  wire logic [psch_pkg::TIME_W-1:0]   burst_time,
	input  wire logic [psch_pkg::PRIO_W-1:0]   priority_level,
	output logic                               rsp_valid,
	input  wire logic                          rsp_ready,
	output logic                               ran,
	output logic      [psch_pkg::PID_W-1:0]    proc_id,
	output logic                               finished,
	output logic      [psch_pkg::TICK_W-1:0]   completion_time,
	output logic      [psch_pkg::TICK_W-1:0]   turnaround,
	output logic      [psch_pkg::TICK_W-1:0]   waiting,
	output logic                               all_done
);

	import psch_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CT,
		ST_TAT,
		ST_WT,
		ST_RESULT
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     done_q;
	logic [TICK_W-1:0]    tick_q;
	logic [CNT_W-1:0]     scan_q;
	logic                 issued_s1;
	logic [IDX_W-1:0]     idx_s1;
	psch_best_t           best_q;
	psch_entry_t          best_word_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic                 fin_q;
	logic [TICK_W-1:0]    ct_q;
	logic [TICK_W-1:0]    tat_q;
	logic [TICK_W-1:0]    wt_q;

	logic                 rsp_valid_q;
	logic                 ran_q;
	logic [PID_W-1:0]     proc_id_q;
	logic                 finished_q;
	logic [TICK_W-1:0]    ct_out_q;
	logic [TICK_W-1:0]    tat_out_q;
	logic [TICK_W-1:0]    wt_out_q;
	logic                 all_done_q;

	logic                 accept;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	psch_entry_t          wr_word;
	logic [ENTRY_W-1:0]   rd_data;
	psch_entry_t          rd_word;
	logic                 take;
	logic                 table_full;
	logic [IDX_W-1:0]     last_idx;
	logic [TIME_W-1:0]    new_rem;
	logic [IDX_W:0]       pid_full;
	logic                 out_free;

	psch_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_PROCS)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_word),
		.raddr(scan_q[IDX_W-1:0]),
		.rdata(rd_data)
	);

	assign rd_word = psch_entry_t'(rd_data);

	psch_cmp u_cmp (
		.word(rd_word),
		.tick(tick_q),
		.best(best_q),
		.take(take)
	);

	always_comb begin
		accept     = cmd_valid && cmd_ready;
		table_full = (count_q >= CNT_W'(MAX_PROCS));
		last_idx   = IDX_W'(count_q - CNT_W'(1));
		new_rem    = best_word_q.remaining - TIME_W'(1);
		pid_full   = {1'b0, best_idx_q} + (IDX_W+1)'(1);
		out_free   = !rsp_valid_q || rsp_ready;
		wr_en      = 1'b0;
		wr_addr    = count_q[IDX_W-1:0];
		wr_word    = '{arrival: arrival_time, burst: burst_time,
		               remaining: burst_time, prio: priority_level};
		if (state_q == ST_CT) begin
			wr_en             = best_q.found;
			wr_addr           = best_idx_q;
			wr_word           = best_word_q;
			wr_word.remaining = new_rem;
		end else if (accept && (func == FUNC_LOAD) && !table_full) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			done_q      <= '0;
			tick_q      <= '0;
			scan_q      <= '0;
			issued_s1   <= 1'b0;
			best_q      <= '0;
			fin_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready && (state_q != ST_RESULT)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (func)
							FUNC_CLEAR: begin
								count_q <= '0;
								done_q  <= '0;
								tick_q  <= '0;
							end
							FUNC_LOAD: begin
								if (!table_full) begin
									count_q <= count_q + CNT_W'(1);
									if (burst_time == '0) begin
										done_q <= done_q + CNT_W'(1);
									end
								end
							end
							FUNC_TICK: begin
								scan_q    <= '0;
								issued_s1 <= 1'b0;
								best_q    <= '0;
								state_q   <= (count_q == '0) ? ST_CT : ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_q < count_q) begin
						scan_q    <= scan_q + CNT_W'(1);
						issued_s1 <= 1'b1;
						idx_s1    <= scan_q[IDX_W-1:0];
					end else begin
						issued_s1 <= 1'b0;
					end
					if (issued_s1 && take) begin
						best_q.found     <= 1'b1;
						best_q.best_prio <= rd_word.prio;
						best_word_q      <= rd_word;
						best_idx_q       <= idx_s1;
					end
					if (issued_s1 && (idx_s1 == last_idx)) begin
						state_q <= ST_CT;
					end
				end
				ST_CT: begin
					fin_q  <= best_q.found && (new_rem == '0);
					if (best_q.found && (new_rem == '0)) begin
						done_q <= done_q + CNT_W'(1);
					end
					ct_q    <= tick_q + TICK_W'(1);
					tick_q  <= tick_q + TICK_W'(1);
					state_q <= ST_TAT;
				end
				ST_TAT: begin
					tat_q   <= ct_q - TICK_W'(best_word_q.arrival);
					state_q <= ST_WT;
				end
				ST_WT: begin
					wt_q    <= tat_q - TICK_W'(best_word_q.burst);
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						ran_q       <= best_q.found;
						proc_id_q   <= best_q.found ? PID_W'(pid_full) : '0;
						finished_q  <= fin_q;
						ct_out_q    <= fin_q ? ct_q : '0;
						tat_out_q   <= fin_q ? tat_q : '0;
						wt_out_q    <= fin_q ? wt_q : '0;
						all_done_q  <= (done_q == count_q);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cmd_ready       = (state_q == ST_IDLE);
	assign rsp_valid       = rsp_valid_q;
	assign ran             = ran_q;
	assign proc_id         = proc_id_q;
	assign finished        = finished_q;
	assign completion_time = ct_out_q;
	assign turnaround      = tat_out_q;
	assign waiting         = wt_out_q;
	assign all_done        = all_done_q;

`ifndef SYNTHESIS
	a_done_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		done_q <= count_q)
		else $error("finished count exceeds loaded count");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (count_q != '0))
		else $error("scan running over an empty table");

	a_idle_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !ran) |-> ((proc_id == '0) && !finished))
		else $error("idle tick reports a process");

	a_finish_ran: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && finished) |-> (ran && (proc_id != '0)))
		else $error("completion reported without a run");
`endif

endmodule

`default_nettype wire
